// File: rtl/subcpu_control_registers_assert.svh
// Assertion macros used by the control-register RTL.
`ifndef SUBCPU_CONTROL_REGISTERS_ASSERT_SVH
`define SUBCPU_CONTROL_REGISTERS_ASSERT_SVH

// Plain property, sampled on clk and switched off while rst_n is low.
`define SCR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define SCR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: rtl/scr_pkg.sv
// Types and constants of the sub CPU control-register block.
`timescale 1ns / 1ps

package scr_pkg;

    typedef enum logic [1:0] {
        CMD_READ     = 2'd0,
        CMD_WRITE    = 2'd1,
        CMD_HALT_ACK = 2'd2,
        CMD_STATUS   = 2'd3
    } scr_cmd_t;

    localparam logic [15:0] ADDR_INTF   = 16'hfd04;
    localparam logic [15:0] ADDR_CTRL   = 16'hfd05;
    localparam logic [15:0] ADDR_MODE   = 16'hfd12;
    localparam logic [15:0] ADDR_BANK   = 16'hfd13;

    localparam logic [7:0] RD_INTF_BUSY = 8'hff;
    localparam logic [7:0] RD_INTF_IDLE = 8'h7f;
    localparam logic [7:0] RD_CTRL_BUSY = 8'hfe;
    localparam logic [7:0] RD_CTRL_IDLE = 8'h7e;
    localparam logic [7:0] RD_ALL_ONES  = 8'hff;

    localparam logic [1:0] VER_MODE_MIN = 2'd2;
    localparam logic [1:0] VER_EXT_MIN  = 2'd3;
    localparam logic [1:0] VER_RESET    = 2'd3;

    localparam logic [1:0] IFACE_RESET  = 2'b01;
    localparam logic [2:0] BANK_EXT     = 3'd4;

    typedef struct packed {
        scr_cmd_t    cmd;
        logic        vsync;
        logic        blanking;
        logic        init_rom_enabled;
        logic        hot_reset;
        logic        break_key;
        logic [7:0]  write_data;
        logic [15:0] address;
    } scr_item_t;

    // Declared from the top bit down so that read_data lands in the low byte.
    typedef struct packed {
        logic [4:0] mode_bits;
        logic       cancel_pending;
        logic       halted;
        logic [2:0] rom_bank;
        logic       video_reset;
        logic       redraw;
        logic       clear_break;
        logic       sub_reset;
        logic       sub_irq;
        logic       main_firq;
        logic       decoded;
        logic [7:0] read_data;
    } scr_result_t;

    localparam int RESULT_W = $bits(scr_result_t);

endpackage

// File: rtl/scr_core.sv
// Register state, address decode and flag updates for one bus command.
`timescale 1ns / 1ps

module scr_core
    import scr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        fire,
    input  scr_item_t   item,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_data,
    output scr_result_t result
);

    logic [1:0] mver_reg;
    logic       halt_request_reg, halt_request_next;
    logic       halt_flag_reg, halt_flag_next;
    logic       busy_flag_reg, busy_flag_next;
    logic       cancel_request_reg, cancel_request_next;
    logic       cancel_flag_reg, cancel_flag_next;
    logic       attention_flag_reg, attention_flag_next;
    logic [2:0] screen_modes_reg, screen_modes_next;
    logic       ram_protect_reg, ram_protect_next;
    logic       kanji_on_sub_reg, kanji_on_sub_next;
    logic       reset_deferred_reg, reset_deferred_next;
    logic [1:0] interface_mode_reg, interface_mode_next;
    logic [2:0] bank_reg, bank_next;

    logic       m400;
    logic       m256;

    always_comb
    begin
        halt_request_next   = halt_request_reg;
        halt_flag_next      = halt_flag_reg;
        busy_flag_next      = busy_flag_reg;
        cancel_request_next = cancel_request_reg;
        cancel_flag_next    = cancel_flag_reg;
        attention_flag_next = attention_flag_reg;
        screen_modes_next   = screen_modes_reg;
        ram_protect_next    = ram_protect_reg;
        kanji_on_sub_next   = kanji_on_sub_reg;
        reset_deferred_next = reset_deferred_reg;
        interface_mode_next = interface_mode_reg;
        bank_next           = bank_reg;

        m400 = ~item.write_data[3];
        m256 = item.write_data[4] & item.write_data[3];

        result = '0;

        case (item.cmd)
            CMD_READ:
            begin
                case (item.address)
                    ADDR_INTF:
                    begin
                        result.decoded   = 1'b1;
                        result.main_firq = 1'b1;
                        result.read_data = busy_flag_reg ? RD_INTF_BUSY : RD_INTF_IDLE;
                        if (attention_flag_reg)
                        begin
                            result.read_data[0] = 1'b0;
                            attention_flag_next = 1'b0;
                        end
                        if (item.break_key || item.hot_reset)
                        begin
                            result.read_data[1] = 1'b0;
                            result.clear_break  = item.hot_reset & ~item.init_rom_enabled;
                        end
                    end
                    ADDR_CTRL:
                    begin
                        result.decoded   = 1'b1;
                        result.read_data = busy_flag_reg ? RD_CTRL_BUSY : RD_CTRL_IDLE;
                    end
                    ADDR_MODE:
                    begin
                        result.decoded   = 1'b1;
                        result.read_data = RD_ALL_ONES;
                        if (mver_reg >= VER_MODE_MIN)
                        begin
                            result.read_data[6] = screen_modes_reg[0];
                            result.read_data[1] = ~item.blanking;
                            result.read_data[0] = item.vsync;
                        end
                    end
                    ADDR_BANK:
                    begin
                        // The bank register is write only and reads back as all ones.
                        result.decoded   = 1'b1;
                        result.read_data = RD_ALL_ONES;
                    end
                    default:
                    begin
                        result.decoded = 1'b0;
                    end
                endcase
            end
            CMD_WRITE:
            begin
                case (item.address)
                    ADDR_INTF:
                    begin
                        result.decoded = 1'b1;
                        if (mver_reg >= VER_EXT_MIN)
                        begin
                            // With 400 line selected the 256k mode is forced off.
                            ram_protect_next    = ~item.write_data[2];
                            kanji_on_sub_next   = ~item.write_data[5];
                            screen_modes_next   = {m256, m400, screen_modes_reg[0]};
                            interface_mode_next = item.write_data[4:3];
                            result.redraw       = (item.write_data[4:3] != interface_mode_reg);
                        end
                    end
                    ADDR_CTRL:
                    begin
                        result.decoded    = 1'b1;
                        result.sub_irq    = 1'b1;
                        halt_request_next = item.write_data[7];
                        if (!item.write_data[7] && reset_deferred_reg)
                        begin
                            result.sub_reset    = 1'b1;
                            reset_deferred_next = 1'b0;
                        end
                        if (item.write_data[6])
                        begin
                            cancel_request_next = 1'b1;
                        end
                    end
                    ADDR_MODE:
                    begin
                        result.decoded = 1'b1;
                        if ((mver_reg >= VER_MODE_MIN)
                            && (item.write_data[6] != screen_modes_reg[0]))
                        begin
                            screen_modes_next[0] = item.write_data[6];
                            result.redraw        = 1'b1;
                        end
                    end
                    ADDR_BANK:
                    begin
                        result.decoded = 1'b1;
                        if (mver_reg >= VER_MODE_MIN)
                        begin
                            if ((mver_reg >= VER_EXT_MIN) && item.write_data[2])
                            begin
                                bank_next = BANK_EXT;
                            end
                            else
                            begin
                                bank_next = {1'b0, item.write_data[1:0]};
                            end
                            // A halted sub CPU is reset only when a later control write releases the halt request.
                            if (!halt_flag_reg)
                            begin
                                result.sub_reset    = 1'b1;
                                reset_deferred_next = 1'b0;
                            end
                            else
                            begin
                                reset_deferred_next = 1'b1;
                            end
                            busy_flag_next     = 1'b1;
                            result.video_reset = 1'b1;
                        end
                    end
                    default:
                    begin
                        result.decoded = 1'b0;
                    end
                endcase
            end
            CMD_HALT_ACK:
            begin
                halt_flag_next   = halt_request_reg;
                cancel_flag_next = cancel_request_reg;
                if (halt_request_reg)
                begin
                    busy_flag_next = 1'b1;
                end
            end
            CMD_STATUS:
            begin
                if (item.write_data[0])
                begin
                    attention_flag_next = 1'b1;
                end
                if (item.write_data[1])
                begin
                    busy_flag_next = 1'b0;
                end
            end
            default:
            begin
                result.decoded = 1'b0;
            end
        endcase

        result.rom_bank       = bank_next;
        result.halted         = halt_flag_next;
        result.cancel_pending = cancel_flag_next;
        result.mode_bits      = {kanji_on_sub_next, ram_protect_next, screen_modes_next};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mver_reg <= VER_RESET;
        end
        else if (cfg_we)
        begin
            mver_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            halt_request_reg   <= 1'b0;
            halt_flag_reg      <= 1'b0;
            busy_flag_reg      <= 1'b1;
            cancel_request_reg <= 1'b0;
            cancel_flag_reg    <= 1'b0;
            attention_flag_reg <= 1'b0;
            screen_modes_reg   <= 3'd0;
            ram_protect_reg    <= 1'b1;
            kanji_on_sub_reg   <= 1'b0;
            reset_deferred_reg <= 1'b0;
            interface_mode_reg <= IFACE_RESET;
            bank_reg           <= 3'd0;
        end
        else if (fire)
        begin
            halt_request_reg   <= halt_request_next;
            halt_flag_reg      <= halt_flag_next;
            busy_flag_reg      <= busy_flag_next;
            cancel_request_reg <= cancel_request_next;
            cancel_flag_reg    <= cancel_flag_next;
            attention_flag_reg <= attention_flag_next;
            screen_modes_reg   <= screen_modes_next;
            ram_protect_reg    <= ram_protect_next;
            kanji_on_sub_reg   <= kanji_on_sub_next;
            reset_deferred_reg <= reset_deferred_next;
            interface_mode_reg <= interface_mode_next;
            bank_reg           <= bank_next;
        end
    end

endmodule

// File: rtl/subcpu_control_registers.sv
// Top level of the sub CPU control-register block: input stage, core and result stage.
//
//   channel   direction  handshake                  payload
//   s_axis    in         s_axis_tvalid/tready       tdata: bus command fields, tuser: cmd
//   m_axis    out        m_axis_tvalid/tready       tdata: result fields
//   cfg       in         cfg_valid/cfg_ready        cfg_data: machine version
//
// Each beat passes through the input register and then the result register.
// One beat is taken every cycle while the result side keeps up; the flag update of the
// core is the only loop.
// Reset sets all flags to their power-on values and empties both stages.
// A stall on m_axis holds the result register, then the input register, then s_axis.
`timescale 1ns / 1ps

module subcpu_control_registers
    import scr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [15:0] address, [23:16] write_data, [24] break_key, [25] hot_reset,
    // [26] init_rom_enabled, [27] blanking, [28] vsync, [31:29] zero
    input  logic [31:0] s_axis_tdata,
    // [1:0] cmd
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] read_data, [8] decoded, [9] main_firq, [10] sub_irq, [11] sub_reset,
    // [12] clear_break, [13] redraw, [14] video_reset, [17:15] rom_bank, [18] halted,
    // [19] cancel_pending, [24:20] mode_bits, [31:25] zero
    output logic [31:0] m_axis_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_data
);

    `include "subcpu_control_registers_assert.svh"

    logic        in_valid_reg, in_valid_next;
    scr_item_t   in_item_reg;
    logic        out_valid_reg, out_valid_next;
    scr_result_t out_result_reg;
    scr_result_t core_result;
    scr_item_t   s_item;
    logic        s_fire;
    logic        advance;

    assign s_item.cmd              = scr_cmd_t'(s_axis_tuser);
    assign s_item.address          = s_axis_tdata[15:0];
    assign s_item.write_data       = s_axis_tdata[23:16];
    assign s_item.break_key        = s_axis_tdata[24];
    assign s_item.hot_reset        = s_axis_tdata[25];
    assign s_item.init_rom_enabled = s_axis_tdata[26];
    assign s_item.blanking         = s_axis_tdata[27];
    assign s_item.vsync            = s_axis_tdata[28];

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    scr_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (advance),
        .item     (in_item_reg),
        .cfg_we   (cfg_valid),
        .cfg_data (cfg_data),
        .result   (core_result)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_fire)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_item_reg <= s_item;
        end
        if (advance)
        begin
            out_result_reg <= core_result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(32 - RESULT_W){1'b0}}, out_result_reg};

    // A bank write either resets the sub CPU now or defers it while halted.
    `SCR_ASSERT_IMP(a_bank_reset_split, out_valid_reg && out_result_reg.video_reset, out_result_reg.sub_reset != out_result_reg.halted, "bank write must reset now or defer")
    // 400 line mode always overrides 256k.
    `SCR_ASSERT_IMP(a_mode_exclusive, out_valid_reg, !(out_result_reg.mode_bits[1] && out_result_reg.mode_bits[2]), "400 line and 256k both set")
    // Only banks 0 through 4 exist.
    `SCR_ASSERT_IMP(a_bank_range, out_valid_reg, out_result_reg.rom_bank <= BANK_EXT, "ROM bank out of range")
    // A stalled result must not be overwritten by the input stage.
    `SCR_ASSERT_IMP(a_no_overrun, out_valid_reg && !m_axis_tready, !advance, "result register overwritten while stalled")

endmodule
